>>> src/cwmf_pkg.sv
// Package for the clamped window median filter.
// Holds register indexes and shared constants; no dependencies.
package cwmf_pkg;
  localparam int unsigned REG_WIDTH  = 0;
  localparam int unsigned REG_HEIGHT = 1;
  localparam int unsigned REG_HALF_X = 2;
  localparam int unsigned REG_HALF_Y = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned PIX_W      = 16;
endpackage

>>> src/cwmf_ram.sv
// Generic single-port write, single-port read RAM with registered read data.
// No dependencies.
module cwmf_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end
endmodule

>>> src/clamped_window_median_filter_top.sv
// Top level of the clamped window median filter.
// Depends on cwmf_pkg and cwmf_ram.
//
// Pixels enter in raster order on the in channel (valid/ready). Each pixel is
// written into a line store of 2*MAX_HALF_Y+1 rows held in one RAM. When a
// pixel completes one or more windows, the block emits their medians on the
// out channel in row-major order, with last_of_run high on the final beat of
// the run. Each median is found by bitwise radix selection: 16 passes, each
// of which reads every window pixel once from the RAM, one read a cycle. For
// a clipped window of an even number of pixels, two order statistics are
// found, each by its own 16 passes, and their mean, rounded down, is the
// median. A pixel that ends no window returns the block to idle after planning.
// One pixel is handled at a time; the next is accepted once all its results
// have been taken. A result waits in the output register while the receiver
// stalls, and the block holds until it is taken. Reset (synchronous, active
// high) restores the register defaults and the position (0,0). Any
// configuration write restarts the frame. The line store needs no clearing:
// every read hits a pixel written earlier in the frame.
module clamped_window_median_filter_top #(
  parameter int unsigned MAX_WIDTH  = 256,
  parameter int unsigned MAX_HALF_X = 7,
  parameter int unsigned MAX_HALF_Y = 7
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [cwmf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [cwmf_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [15:0]                    pixel_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_col,
  output logic [15:0]                    out_row,
  output logic [15:0]                    median_value,
  output logic                           last_of_run
);
  import cwmf_pkg::*;

  localparam int unsigned RING  = 2 * MAX_HALF_Y + 1;
  localparam int unsigned COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int unsigned RR_W  = $clog2(RING + 1);
  localparam int unsigned DEPTH = RING * MAX_WIDTH;
  localparam int unsigned AD_W  = $clog2(DEPTH);
  localparam int unsigned WIN_W = $clog2((2 * MAX_HALF_X + 1) * RING + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_PLAN, S_SETUP, S_PASS, S_DRAIN, S_BIT, S_OUT
  } state_t;

  // Configuration registers.
  logic [8:0]  image_width;
  logic [15:0] image_height;
  logic [2:0]  half_width, half_height;

  // Effective configuration.
  logic [COL_W:0] w_eff;
  logic [15:0]    h_eff;
  logic [2:0]     hx, hy;
  always_comb begin
    if (image_width == 9'd0) begin
      w_eff = (COL_W + 1)'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = (COL_W + 1)'(MAX_WIDTH);
    end else begin
      w_eff = (COL_W + 1)'(image_width);
    end
    h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
    hx = (32'(half_width) > MAX_HALF_X) ? 3'(MAX_HALF_X) : half_width;
    hy = (32'(half_height) > MAX_HALF_Y) ? 3'(MAX_HALF_Y) : half_height;
  end

  state_t state;
  logic [COL_W:0] in_col;
  logic [15:0]    in_row;
  logic [RR_W-1:0] ring_row;      // in_row mod RING
  logic [COL_W:0] c_cur;
  logic [15:0]    r_cur;
  logic [RR_W-1:0] rr_cur, rr_acc;
  // Output run bounds.
  logic [COL_W:0] x0, x1, ox;
  logic [15:0]    y1, oy;
  // Window of the current output.
  logic [COL_W:0] xs, xe, rx;
  logic [15:0]    ys, ye, ry;
  logic [RR_W-1:0] ry_ring, ys_ring;
  logic [WIN_W-1:0] win_n, kk, cnt;
  logic [15:0]    prefix, first_val;
  logic [3:0]     bitpos;
  logic           second, scan_done, rd_pend;
  logic [15:0]    rd_data;
  logic           wr_en;
  logic [AD_W-1:0] wr_addr, rd_addr;

  assign in_ready = (state == S_IDLE) && !cfg_write &&
                    (in_col < w_eff) && (in_row < h_eff);
  assign wr_en    = in_valid && in_ready;
  assign wr_addr  = AD_W'(32'(rr_cur) * MAX_WIDTH + 32'(in_col[COL_W-1:0]));
  assign rd_addr  = AD_W'(32'(ry_ring) * MAX_WIDTH + 32'(rx[COL_W-1:0]));

  cwmf_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_store (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(pixel_value),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  // Radix test on the returned word.
  logic [15:0] hi_mask;
  logic        hit;
  always_comb begin
    hi_mask = 16'hFFFF << (5'(bitpos) + 5'd1);
    hit = (((rd_data ^ prefix) & hi_mask) == 16'd0) && !rd_data[bitpos];
  end

  // Window bounds of output (ox, oy).
  logic [COL_W:0] wxs, wxe;
  logic [15:0]    wys, wye;
  logic [16:0]    wsum;
  logic [15:0]    wdist;
  logic [RR_W-1:0] wys_ring;
  logic [WIN_W-1:0] wn;
  always_comb begin
    wxs = (ox >= (COL_W + 1)'(hx)) ? ox - (COL_W + 1)'(hx) : '0;
    wxe = ((ox + (COL_W + 1)'(hx)) < w_eff - 1'b1) ? ox + (COL_W + 1)'(hx) : w_eff - 1'b1;
    wys = (oy >= 16'(hy)) ? oy - 16'(hy) : 16'd0;
    wsum = 17'(oy) + 17'(hy);
    wye = (wsum < 17'(h_eff) - 17'd1) ? wsum[15:0] : h_eff - 16'd1;
    // The top window row lies less than RING rows above the row just written.
    wdist = r_cur - wys;
    wys_ring = (rr_acc >= RR_W'(wdist)) ? rr_acc - RR_W'(wdist)
        : RR_W'((RR_W + 1)'(rr_acc) + (RR_W + 1)'(RING) - (RR_W + 1)'(wdist));
    wn = WIN_W'((32'(wxe) - 32'(wxs) + 1) * (32'(wye) - 32'(wys) + 1));
  end

  assign rr_cur = ring_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      image_width <= 9'd256; image_height <= 16'd256;
      half_width <= 3'd1; half_height <= 3'd1;
      in_col <= '0; in_row <= '0; ring_row <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (32'(cfg_index))
          REG_WIDTH:  image_width  <= cfg_data[8:0];
          REG_HEIGHT: image_height <= cfg_data;
          REG_HALF_X: half_width   <= cfg_data[2:0];
          REG_HALF_Y: half_height  <= cfg_data[2:0];
          default: ;
        endcase
        in_col <= '0; in_row <= '0; ring_row <= '0;
      end
      case (state)
        S_IDLE: begin
          if (!cfg_write && (in_col >= w_eff || in_row >= h_eff)) begin
            in_col <= '0; in_row <= '0; ring_row <= '0;
          end else if (wr_en) begin
            c_cur <= in_col; r_cur <= in_row; rr_acc <= ring_row;
            // Advance position.
            if (in_col + 1'b1 >= w_eff) begin
              in_col <= '0;
              if (in_row + 16'd1 >= h_eff) begin
                in_row <= '0; ring_row <= '0;
              end else begin
                in_row <= in_row + 16'd1;
                ring_row <= (32'(ring_row) == RING - 1) ? '0 : ring_row + 1'b1;
              end
            end else begin
              in_col <= in_col + 1'b1;
            end
            state <= S_PLAN;
          end
        end
        S_PLAN: begin
          // Decide which outputs this pixel completes.
          logic hr, hc;
          hr = 1'b1; hc = 1'b1;
          if (r_cur == h_eff - 16'd1) begin
            y1 <= r_cur;
            oy <= (r_cur >= 16'(hy)) ? r_cur - 16'(hy) : 16'd0;
          end else if (r_cur >= 16'(hy)) begin
            y1 <= r_cur - 16'(hy); oy <= r_cur - 16'(hy);
          end else begin
            hr = 1'b0;
          end
          if (c_cur == w_eff - 1'b1) begin
            x0 <= (c_cur >= (COL_W + 1)'(hx)) ? c_cur - (COL_W + 1)'(hx) : '0;
            ox <= (c_cur >= (COL_W + 1)'(hx)) ? c_cur - (COL_W + 1)'(hx) : '0;
            x1 <= c_cur;
          end else if (c_cur >= (COL_W + 1)'(hx)) begin
            x0 <= c_cur - (COL_W + 1)'(hx); x1 <= c_cur - (COL_W + 1)'(hx);
            ox <= c_cur - (COL_W + 1)'(hx);
          end else begin
            hc = 1'b0;
          end
          state <= (hr && hc) ? S_SETUP : S_IDLE;
          rd_pend <= 1'b0;
        end
        S_SETUP: begin
          // Latch the clipped window of the next output; the lower middle
          // rank comes first, which is the middle rank for an odd count.
          xs <= wxs; xe <= wxe; ys <= wys; ye <= wye;
          ys_ring <= wys_ring;
          win_n <= wn;
          kk <= (wn - 1'b1) >> 1;
          second <= 1'b0; bitpos <= 4'd15; prefix <= 16'd0;
          state <= S_BIT;
        end
        S_BIT: begin
          // Begin a new radix pass.
          rx <= xs; ry <= ys; ry_ring <= ys_ring;
          cnt <= '0; scan_done <= 1'b0; rd_pend <= 1'b0;
          state <= S_PASS;
        end
        S_PASS: begin
          // One read per cycle; count hits of the word read last cycle.
          if (rd_pend && hit) cnt <= cnt + 1'b1;
          rd_pend <= !scan_done;
          if (!scan_done) begin
            if (rx == xe) begin
              rx <= xs;
              if (ry == ye) begin
                scan_done <= 1'b1;
              end else begin
                ry <= ry + 16'd1;
                ry_ring <= (32'(ry_ring) == RING - 1) ? '0 : ry_ring + 1'b1;
              end
            end else begin
              rx <= rx + 1'b1;
            end
          end else if (!rd_pend) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          // Resolve one bit of the order statistic.
          logic [15:0] pnew;
          pnew = prefix;
          if (kk >= cnt) begin
            kk <= kk - cnt;
            pnew = prefix | (16'd1 << bitpos);
          end
          prefix <= pnew;
          if (bitpos != 4'd0) begin
            bitpos <= bitpos - 4'd1;
            state <= S_BIT;
          end else if (win_n[0] == 1'b0 && !second) begin
            first_val <= pnew; second <= 1'b1;
            kk <= WIN_W'(win_n >> 1);
            bitpos <= 4'd15; prefix <= 16'd0;
            state <= S_PASS;
            rx <= xs; ry <= ys; ry_ring <= ys_ring;
            cnt <= '0; scan_done <= 1'b0; rd_pend <= 1'b0;
          end else begin
            median_value <= (win_n[0] == 1'b0)
                ? 16'((17'(first_val) + 17'(pnew)) >> 1) : pnew;
            out_col <= ox[7:0]; out_row <= oy;
            last_of_run <= (ox == x1) && (oy == y1);
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (ox == x1 && oy == y1) begin
              state <= S_IDLE;
            end else begin
              if (ox == x1) begin
                ox <= x0; oy <= oy + 16'd1;
              end else begin
                ox <= ox + 1'b1;
              end
              state <= S_SETUP;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Checks on the control flow.
  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !in_ready) else $error("input taken while busy");
  a_out_only_in_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (state == S_OUT)) else $error("result shown outside output state");
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(median_value)))
    else $error("stalled result changed");
endmodule
